// ===== sv/slotted_page_space_manager_unit_macros.svh =====
// Assertion macros used by the port-level checker of the slotted page space manager.
`ifndef SLOTTED_PAGE_SPACE_MANAGER_UNIT_MACROS_SVH
`define SLOTTED_PAGE_SPACE_MANAGER_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SPSM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SPSM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/spsm_pkg.sv =====
// Package with the types, sizes and codes of the slotted page space manager.
package spsm_pkg;

  // Page geometry.
  localparam int PAGE_BYTES   = 4096;
  localparam int HEADER_BYTES = 16;
  localparam int ENTRY_BYTES  = 8;
  localparam int MAX_SLOTS    = 512;

  // Field and internal widths.
  localparam int KIND_W   = 2;
  localparam int BYTE_W   = 13;
  localparam int SLOT_W   = 9;
  localparam int CNT_W    = 10;
  localparam int STATUS_W = 2;
  localparam int SUM_W    = BYTE_W + SLOT_W;

  typedef logic [KIND_W-1:0]   kind_t;
  typedef logic [BYTE_W-1:0]   bytes_t;
  typedef logic [SLOT_W-1:0]   slot_t;
  typedef logic [CNT_W-1:0]    count_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [SUM_W-1:0]    sum_t;

  // One slot directory entry as held in memory.
  typedef struct packed {
    bytes_t offset;
    bytes_t size;
    logic   deleted;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Item kinds.
  localparam kind_t KIND_INIT   = 2'd0;
  localparam kind_t KIND_ALLOC  = 2'd1;
  localparam kind_t KIND_DELETE = 2'd2;
  localparam kind_t KIND_VACUUM = 2'd3;

  // Result status codes.
  localparam status_t ST_OK      = 2'd0;
  localparam status_t ST_NOSPACE = 2'd1;
  localparam status_t ST_RANGE   = 2'd2;

endpackage

// ===== sv/slotted_page_space_manager_unit.sv =====
// Top level of the slotted page space manager: sequencer around the slot directory RAM.
// Usage: one page's slot directory. An item (kind, tuple_bytes, target_slot) is
// transferred when item_valid is high and item_stall is low; exactly one result
// (status, granted_slot, granted_offset, slots_in_use, free_begin, free_limit)
// follows on the result channel, transferred when result_valid is high and
// result_stall is low. Items are handled one at a time: item_stall stays high
// from the transfer until the result has been loaded into the output register.
// All directory accesses go through one directory RAM with a registered read; a
// vacuum also keeps the new offsets in a second RAM, and its pairwise offset
// comparison streams the whole directory once for every live slot.
// The output register frees the sequencer: a new item is taken while the last
// result still waits. If result_stall holds the previous result when the next
// one is ready, the sequencer waits and the held result does not change.
// Reset (rst, synchronous) clears the header to an empty page: no slots, free
// space from the header end to the page end. Directory contents are not
// cleared, and no clearing pass runs; only entries below the slot count are read.
module slotted_page_space_manager_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      item_valid,
  output logic                      item_stall,
  input  spsm_pkg::kind_t           kind,
  input  spsm_pkg::bytes_t          tuple_bytes,
  input  spsm_pkg::slot_t           target_slot,
  output logic                      result_valid,
  input  logic                      result_stall,
  output spsm_pkg::status_t         status,
  output spsm_pkg::slot_t           granted_slot,
  output spsm_pkg::bytes_t          granted_offset,
  output spsm_pkg::count_t          slots_in_use,
  output spsm_pkg::bytes_t          free_begin,
  output spsm_pkg::bytes_t          free_limit
);

  import spsm_pkg::*;

  // Sequencer state codes.
  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_SCAN    = 4'd1;
  localparam logic [3:0] S_APPEND  = 4'd2;
  localparam logic [3:0] S_DEL_RD  = 4'd3;
  localparam logic [3:0] S_DEL_WR  = 4'd4;
  localparam logic [3:0] S_V_RD_I  = 4'd5;
  localparam logic [3:0] S_V_CAP_I = 4'd6;
  localparam logic [3:0] S_V_INNER = 4'd7;
  localparam logic [3:0] S_V_COPY  = 4'd8;
  localparam logic [3:0] S_DONE    = 4'd9;

  localparam bytes_t PAGE_END   = BYTE_W'(PAGE_BYTES);
  localparam bytes_t HEADER_END = BYTE_W'(HEADER_BYTES);
  localparam sum_t   PAGE_SUM   = SUM_W'(PAGE_BYTES);

  logic [3:0] state;

  // Page header.
  count_t slot_total;
  bytes_t space_start;
  bytes_t space_end;

  // Item latched at transfer and result under construction.
  bytes_t  req;
  slot_t   target;
  status_t status_r;
  slot_t   gslot_r;
  bytes_t  goff_r;

  // Directory scan engine: issue pointer and pending read.
  count_t ptr;
  logic   pend;
  slot_t  pend_idx;

  // Vacuum working registers.
  slot_t  outer;
  bytes_t off_i;
  sum_t   acc;
  sum_t   live_sum;

  // RAM connections.
  logic   ent_wr_en;
  slot_t  ent_wr_addr;
  entry_t ent_wr_data;
  slot_t  ent_rd_addr;
  entry_t ent_rd;
  logic   noff_wr_en;
  bytes_t noff_wr_data;
  bytes_t noff_rd;

  // Decisions of the shared compare and add logic.
  slot_t  last_idx;
  logic   last;
  logic   outer_last;
  logic   hit;
  logic   counts;
  bytes_t free_bytes;
  logic   append_ok;
  bytes_t append_off;
  sum_t   acc_next;
  sum_t   live_sum_next;
  bytes_t new_off_live;
  bytes_t space_end_vac;

  spsm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_SLOTS)
  ) u_entry_ram (
    .clk     (clk),
    .wr_en   (ent_wr_en),
    .wr_addr (ent_wr_addr),
    .wr_data (ent_wr_data),
    .rd_addr (ent_rd_addr),
    .rd_data (ent_rd)
  );

  spsm_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MAX_SLOTS)
  ) u_new_off_ram (
    .clk     (clk),
    .wr_en   (noff_wr_en),
    .wr_addr (outer),
    .wr_data (noff_wr_data),
    .rd_addr (ptr[SLOT_W-1:0]),
    .rd_data (noff_rd)
  );

  assign item_stall = (state != S_IDLE);

  // Shared compare and add logic used by every scan.
  always_comb begin
    last_idx      = SLOT_W'(slot_total - count_t'(1));
    last          = pend && (pend_idx == last_idx);
    outer_last    = (outer == last_idx);
    hit           = pend && ent_rd.deleted && (ent_rd.size >= req);
    free_bytes    = (space_end >= space_start) ? space_end - space_start : '0;
    append_ok     = (slot_total < CNT_W'(MAX_SLOTS)) &&
                    ((BYTE_W + 1)'(ENTRY_BYTES) + {1'b0, req} <= {1'b0, free_bytes});
    append_off    = space_end - req;
    counts        = pend && !ent_rd.deleted &&
                    ((ent_rd.offset > off_i) ||
                     ((ent_rd.offset == off_i) && (pend_idx <= outer)));
    acc_next      = acc + (counts ? SUM_W'(ent_rd.size) : '0);
    live_sum_next = live_sum + SUM_W'(ent_rd.size);
    new_off_live  = (acc_next > PAGE_SUM) ? '0 : BYTE_W'(PAGE_SUM - acc_next);
    space_end_vac = (live_sum > PAGE_SUM) ? '0 : BYTE_W'(PAGE_SUM - live_sum);
  end

  // RAM port control per sequencer state.
  always_comb begin
    ent_wr_en    = 1'b0;
    ent_wr_addr  = pend_idx;
    ent_wr_data  = ent_rd;
    ent_rd_addr  = ptr[SLOT_W-1:0];
    noff_wr_en   = 1'b0;
    noff_wr_data = ent_rd.offset;
    unique case (state)
      S_SCAN: begin
        ent_wr_en   = hit;
        ent_wr_data = '{offset: ent_rd.offset, size: req, deleted: 1'b0};
      end
      S_APPEND: begin
        ent_wr_en   = append_ok;
        ent_wr_addr = slot_total[SLOT_W-1:0];
        ent_wr_data = '{offset: append_off, size: req, deleted: 1'b0};
      end
      S_DEL_RD: begin
        ent_rd_addr = target;
      end
      S_DEL_WR: begin
        ent_wr_en   = 1'b1;
        ent_wr_addr = target;
        ent_wr_data = '{offset: ent_rd.offset, size: ent_rd.size, deleted: 1'b1};
      end
      S_V_RD_I: begin
        ent_rd_addr = outer;
      end
      S_V_CAP_I: begin
        noff_wr_en   = ent_rd.deleted;
        noff_wr_data = ent_rd.offset;
      end
      S_V_INNER: begin
        noff_wr_en   = last;
        noff_wr_data = new_off_live;
      end
      S_V_COPY: begin
        ent_wr_en   = pend;
        ent_wr_data = '{offset:  noff_rd,
                        size:    ent_rd.deleted ? '0 : ent_rd.size,
                        deleted: ent_rd.deleted};
      end
      default: begin
      end
    endcase
  end

  // Sequencer, header and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
      slot_total   <= '0;
      space_start  <= HEADER_END;
      space_end    <= PAGE_END;
      pend         <= 1'b0;
    end else begin
      // A transfer empties the output register unless a new result is loaded.
      if (result_valid && !result_stall && state != S_DONE) begin
        result_valid <= 1'b0;
      end

      // The scan states stream the directory one entry per cycle.
      if (state == S_SCAN || state == S_V_INNER || state == S_V_COPY) begin
        if (ptr < slot_total) begin
          ptr      <= ptr + count_t'(1);
          pend     <= 1'b1;
          pend_idx <= ptr[SLOT_W-1:0];
        end else begin
          pend <= 1'b0;
        end
      end

      unique case (state)
        S_IDLE: begin
          if (item_valid) begin
            req      <= tuple_bytes;
            target   <= target_slot;
            status_r <= ST_OK;
            gslot_r  <= '0;
            goff_r   <= '0;
            ptr      <= '0;
            pend     <= 1'b0;
            outer    <= '0;
            live_sum <= '0;
            unique case (kind)
              KIND_INIT: begin
                slot_total  <= '0;
                space_start <= HEADER_END;
                space_end   <= PAGE_END;
                state       <= S_DONE;
              end
              KIND_ALLOC: begin
                state <= (slot_total == '0) ? S_APPEND : S_SCAN;
              end
              KIND_DELETE: begin
                if ({1'b0, target_slot} >= slot_total) begin
                  status_r <= ST_RANGE;
                  state    <= S_DONE;
                end else begin
                  state <= S_DEL_RD;
                end
              end
              KIND_VACUUM: begin
                if (slot_total == '0) begin
                  space_end <= PAGE_END;
                  state     <= S_DONE;
                end else begin
                  state <= S_V_RD_I;
                end
              end
            endcase
          end
        end
        S_SCAN: begin
          // Reuse the lowest deleted slot that is large enough.
          if (hit) begin
            gslot_r <= pend_idx;
            goff_r  <= ent_rd.offset;
            state   <= S_DONE;
          end else if (last) begin
            state <= S_APPEND;
          end
        end
        S_APPEND: begin
          if (append_ok) begin
            slot_total  <= slot_total + count_t'(1);
            space_start <= space_start + BYTE_W'(ENTRY_BYTES);
            space_end   <= append_off;
            gslot_r     <= slot_total[SLOT_W-1:0];
            goff_r      <= append_off;
          end else begin
            status_r <= ST_NOSPACE;
          end
          state <= S_DONE;
        end
        S_DEL_RD: begin
          state <= S_DEL_WR;
        end
        S_DEL_WR: begin
          state <= S_DONE;
        end
        S_V_RD_I: begin
          state <= S_V_CAP_I;
        end
        S_V_CAP_I: begin
          // A deleted slot keeps its offset; a live one starts a pass.
          off_i <= ent_rd.offset;
          if (ent_rd.deleted) begin
            if (outer_last) begin
              ptr   <= '0;
              pend  <= 1'b0;
              state <= S_V_COPY;
            end else begin
              outer <= outer + slot_t'(1);
              state <= S_V_RD_I;
            end
          end else begin
            live_sum <= live_sum_next;
            acc      <= '0;
            ptr      <= '0;
            pend     <= 1'b0;
            state    <= S_V_INNER;
          end
        end
        S_V_INNER: begin
          // Sum the live sizes placed above this slot, itself and lower slots at its offset included.
          // On the last entry the pointer has run off the end, so the scan clears the pending read.
          acc <= acc_next;
          if (last) begin
            ptr <= '0;
            if (outer_last) begin
              state <= S_V_COPY;
            end else begin
              outer <= outer + slot_t'(1);
              state <= S_V_RD_I;
            end
          end
        end
        S_V_COPY: begin
          if (last) begin
            space_end <= space_end_vac;
            state     <= S_DONE;
          end
        end
        S_DONE: begin
          // Load the result once the output register is free.
          if (!result_valid || !result_stall) begin
            result_valid   <= 1'b1;
            status         <= status_r;
            granted_slot   <= gslot_r;
            granted_offset <= goff_r;
            slots_in_use   <= slot_total;
            free_begin     <= space_start;
            free_limit     <= space_end;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== sv/spsm_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module spsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== sv/spsm_checker.sv =====
// Port-level checker for the slotted page space manager, bound to the top level.
`include "slotted_page_space_manager_unit_macros.svh"

module spsm_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      item_valid,
  input logic                      item_stall,
  input spsm_pkg::kind_t           kind,
  input spsm_pkg::bytes_t          tuple_bytes,
  input spsm_pkg::slot_t           target_slot,
  input logic                      result_valid,
  input logic                      result_stall,
  input spsm_pkg::status_t         status,
  input spsm_pkg::slot_t           granted_slot,
  input spsm_pkg::bytes_t          granted_offset,
  input spsm_pkg::count_t          slots_in_use,
  input spsm_pkg::bytes_t          free_begin,
  input spsm_pkg::bytes_t          free_limit
);

  import spsm_pkg::*;

  // A stalled result holds its value.
  `SPSM_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(status) && $stable(granted_slot) && $stable(granted_offset) && $stable(free_limit), "stalled result changed")

  // The block works on one item at a time.
  `SPSM_ASSERT_NEXT(a_busy_after_item, item_valid && !item_stall, item_stall, "item taken while busy")

  // A failed item grants nothing.
  `SPSM_ASSERT_SAME(a_no_grant, result_valid && status != ST_OK, granted_slot == '0 && granted_offset == '0, "grant on failed item")

  // The free space always starts right after the slot directory.
  `SPSM_ASSERT_SAME(a_dir_end, result_valid, free_begin == BYTE_W'(HEADER_BYTES + ENTRY_BYTES * int'(slots_in_use)), "free space start does not follow slot count")

endmodule

bind slotted_page_space_manager_unit spsm_checker u_spsm_checker (.*);

// ===== sim/page_directory_checker.sv =====
// Checker that predicts every page directory reply and compares it with the block's result.
`timescale 1ns / 100ps

module page_directory_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  logic              item_stall,
  input  spsm_pkg::kind_t   kind,
  input  spsm_pkg::bytes_t  tuple_bytes,
  input  spsm_pkg::slot_t   target_slot,
  input  logic              result_valid,
  input  logic              result_stall,
  input  spsm_pkg::status_t status,
  input  spsm_pkg::slot_t   granted_slot,
  input  spsm_pkg::bytes_t  granted_offset,
  input  spsm_pkg::count_t  slots_in_use,
  input  spsm_pkg::bytes_t  free_begin,
  input  spsm_pkg::bytes_t  free_limit,
  output int                fail_count,
  output int                results_owed,
  output int                slots_hint
);

  import spsm_pkg::*;

  // One reply of the page, in the order of the result ports.
  typedef struct packed {
    status_t status;
    slot_t   slot;
    bytes_t  offset;
    count_t  used;
    bytes_t  fbegin;
    bytes_t  flimit;
  } page_reply_t;

  // Our own copy of the slot directory and the page header.
  bytes_t tuple_at   [MAX_SLOTS];
  bytes_t tuple_len  [MAX_SLOTS];
  logic   tuple_gone [MAX_SLOTS];
  int     slot_cnt;
  int     free_lo;
  int     free_hi;

  page_reply_t replies_owed [$];
  int          mismatches = 0;

  // Empty page: no slots, free space from the header end to the page end.
  function automatic void reset_header();
    slot_cnt = 0;
    free_lo  = HEADER_BYTES;
    free_hi  = PAGE_BYTES;
  endfunction

  // Vacuum: deleted sizes drop to zero and live tuples are packed down from the
  // page end by decreasing old offset, the lower slot first on equal offsets.
  function void compact_page();
    int moved [MAX_SLOTS];
    int live_sum;
    int acc;
    live_sum = 0;
    for (int i = 0; i < slot_cnt; i++) begin
      if (tuple_gone[i]) tuple_len[i] = '0;
    end
    for (int i = 0; i < slot_cnt; i++) begin
      if (tuple_gone[i]) begin
        moved[i] = int'(tuple_at[i]);
      end else begin
        live_sum += int'(tuple_len[i]);
        acc = 0;
        for (int j = 0; j < slot_cnt; j++) begin
          if (!tuple_gone[j] && (tuple_at[j] > tuple_at[i] ||
              (tuple_at[j] == tuple_at[i] && j <= i)))
            acc += int'(tuple_len[j]);
        end
        moved[i] = (acc > PAGE_BYTES) ? 0 : PAGE_BYTES - acc;
      end
    end
    for (int i = 0; i < slot_cnt; i++) tuple_at[i] = bytes_t'(moved[i]);
    free_hi = (live_sum > PAGE_BYTES) ? 0 : PAGE_BYTES - live_sum;
  endfunction

  // Applies one request to the directory and returns the reply it should give.
  function page_reply_t apply_request(kind_t k, bytes_t req, slot_t tgt);
    page_reply_t r;
    int          free_bytes;
    bit          reused;
    r        = '0;
    r.status = ST_OK;
    reused   = 1'b0;
    case (k)
      KIND_INIT: reset_header();
      KIND_ALLOC: begin
        // Lowest deleted slot that is big enough keeps its offset.
        for (int i = 0; i < slot_cnt && !reused; i++) begin
          if (tuple_gone[i] && tuple_len[i] >= req) begin
            tuple_len[i]  = req;
            tuple_gone[i] = 1'b0;
            r.slot        = slot_t'(i);
            r.offset      = tuple_at[i];
            reused        = 1'b1;
          end
        end
        // Otherwise append a new slot if its entry and the tuple fit.
        if (!reused) begin
          free_bytes = (free_hi >= free_lo) ? free_hi - free_lo : 0;
          if (slot_cnt >= MAX_SLOTS || ENTRY_BYTES + int'(req) > free_bytes) begin
            r.status = ST_NOSPACE;
          end else begin
            tuple_at[slot_cnt]   = bytes_t'(free_hi - int'(req));
            tuple_len[slot_cnt]  = req;
            tuple_gone[slot_cnt] = 1'b0;
            r.slot               = slot_t'(slot_cnt);
            r.offset             = tuple_at[slot_cnt];
            slot_cnt++;
            free_lo += ENTRY_BYTES;
            free_hi -= int'(req);
          end
        end
      end
      KIND_DELETE: begin
        if (int'(tgt) >= slot_cnt) r.status = ST_RANGE;
        else tuple_gone[tgt] = 1'b1;
      end
      default: compact_page();
    endcase
    r.used   = count_t'(slot_cnt);
    r.fbegin = bytes_t'(free_lo);
    r.flimit = bytes_t'(free_hi);
    return r;
  endfunction

  // Result transfers are matched first, so a reply can never meet its own request.
  always @(posedge clk) begin
    page_reply_t got;
    page_reply_t want;
    if (rst) begin
      reset_header();
      replies_owed.delete();
    end else begin
      if (result_valid && !result_stall) begin
        got = {status, granted_slot, granted_offset, slots_in_use, free_begin, free_limit};
        if (replies_owed.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected reply: st=%0d slot=%0d off=%0d used=%0d begin=%0d limit=%0d",
                     got.status, got.slot, got.offset, got.used, got.fbegin, got.flimit);
        end else begin
          want = replies_owed.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("reply differs: want st=%0d slot=%0d off=%0d used=%0d begin=%0d limit=%0d",
                       want.status, want.slot, want.offset, want.used, want.fbegin,
                       want.flimit);
              $display("               got  st=%0d slot=%0d off=%0d used=%0d begin=%0d limit=%0d",
                       got.status, got.slot, got.offset, got.used, got.fbegin, got.flimit);
            end
          end
        end
      end
      if (item_valid && !item_stall)
        replies_owed.push_back(apply_request(kind, tuple_bytes, target_slot));
    end
    results_owed <= replies_owed.size();
    slots_hint   <= slot_cnt;
    fail_count   <= mismatches;
  end

endmodule

// ===== sim/tb.sv =====
// Testbench top: drives page requests and result stalls and reports the verdict.
`timescale 1ns / 100ps

module tb;
  import spsm_pkg::*;

  // Far above the slowest run at the slot counts used here.
  localparam int CYCLE_LIMIT  = 6_000_000;
  localparam int RANDOM_ITEMS = 800;

  logic    clk          = 1'b0;
  logic    rst          = 1'b1;
  logic    item_valid   = 1'b0;
  logic    result_stall = 1'b0;
  kind_t   kind         = KIND_INIT;
  bytes_t  tuple_bytes  = '0;
  slot_t   target_slot  = '0;
  logic    item_stall;
  logic    result_valid;
  status_t status;
  slot_t   granted_slot;
  bytes_t  granted_offset;
  count_t  slots_in_use;
  bytes_t  free_begin;
  bytes_t  free_limit;
  int      fail_count;
  int      results_owed;
  int      slots_hint;
  int      cycles     = 0;
  int      items_sent = 0;
  int      burst_left = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  slotted_page_space_manager_unit dut (.*);

  page_directory_checker page_check (.*);

  // Timeout guard.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("slotted_page_space_manager_unit: mismatch");
      $finish;
    end
  end

  // Result side: a random warm-up, one long hold-off that backs the block up,
  // then stretches of differing stall density, some with no stall at all.
  initial begin : result_side
    int pct;
    int span;
    wait (!rst);
    @(posedge clk);
    repeat (120) begin
      result_stall <= ($urandom_range(0, 1) == 1);
      @(posedge clk);
    end
    result_stall <= 1'b1;
    repeat (700) @(posedge clk);
    forever begin
      case ($urandom_range(0, 3))
        0:       pct = 0;
        1:       pct = 25;
        2:       pct = 60;
        default: pct = 90;
      endcase
      span = $urandom_range(10, 300);
      repeat (span) begin
        result_stall <= ($urandom_range(0, 99) < pct);
        @(posedge clk);
      end
    end
  end

  // Offers one request and returns at the edge of its transfer. Requests come in
  // bursts with random gaps between them.
  task automatic offer(input kind_t k, input int nbytes, input int slot);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      case ($urandom_range(0, 7))
        0, 1:    gap = 0;
        7:       gap = $urandom_range(20, 80);
        default: gap = $urandom_range(1, 6);
      endcase
      if (gap != 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    item_valid  <= 1'b1;
    kind        <= k;
    tuple_bytes <= bytes_t'(nbytes);
    target_slot <= slot_t'(slot);
    do @(posedge clk); while (item_stall);
    items_sent++;
  endtask

  // Stops sending until every reply owed has arrived.
  task automatic drain();
    item_valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
  endtask

  // Tuple sizes lean small so pages hold a fair number of slots.
  function automatic int pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return $urandom_range(0, 48);
    if (r < 80) return $urandom_range(49, 300);
    if (r < 92) return $urandom_range(301, 2000);
    if (r < 96) return PAGE_BYTES;
    return $urandom_range(0, PAGE_BYTES);
  endfunction

  // Mostly slots that exist, sometimes any slot number.
  function automatic int pick_target();
    if ($urandom_range(0, 99) < 85) return $urandom_range(0, slots_hint);
    return $urandom_range(0, MAX_SLOTS - 1);
  endfunction

  // Hand-picked sequence: empty page, equal offsets, exact fit, no space,
  // out-of-range and repeated deletes, reuse that skips a slot too small,
  // vacuum with ties, reuse of a vacuumed slot.
  task automatic run_directed();
    offer(KIND_DELETE, 0, 0);
    offer(KIND_VACUUM, 0, 0);
    offer(KIND_ALLOC, 0, 0);
    offer(KIND_ALLOC, 0, 0);
    offer(KIND_ALLOC, PAGE_BYTES, 0);
    offer(KIND_ALLOC, 100, 0);
    offer(KIND_ALLOC, 50, 0);
    offer(KIND_ALLOC, 70, 0);
    offer(KIND_DELETE, 0, MAX_SLOTS - 1);
    offer(KIND_DELETE, 0, 2);
    offer(KIND_DELETE, 0, 2);
    offer(KIND_ALLOC, 60, 0);
    offer(KIND_DELETE, 0, 3);
    offer(KIND_DELETE, 0, 4);
    offer(KIND_ALLOC, 60, 0);
    offer(KIND_VACUUM, 0, 0);
    offer(KIND_ALLOC, 0, 0);
    offer(KIND_INIT, PAGE_BYTES, MAX_SLOTS - 1);
    offer(KIND_ALLOC, PAGE_BYTES - HEADER_BYTES - ENTRY_BYTES, 0);
    offer(KIND_ALLOC, 0, 0);
    offer(KIND_DELETE, 0, 0);
    offer(KIND_VACUUM, 0, 0);
    offer(KIND_ALLOC, 1, 0);
    offer(KIND_INIT, 0, 0);
    drain();
  endtask

  // One page's life: fresh page, some appends, then a mix of deletes, allocates
  // and vacuums. Tiny pages use near-zero tuples to reach many slots.
  task automatic page_session(input int n_alloc, input int n_ops, input bit tiny);
    int r;
    offer(KIND_INIT, $urandom_range(0, PAGE_BYTES), $urandom_range(0, MAX_SLOTS - 1));
    repeat (n_alloc)
      offer(KIND_ALLOC, tiny ? $urandom_range(0, 3) : pick_size(),
            $urandom_range(0, MAX_SLOTS - 1));
    repeat (n_ops) begin
      r = $urandom_range(0, 99);
      if (r < 35)
        offer(KIND_DELETE, $urandom_range(0, PAGE_BYTES), pick_target());
      else if (r < 85)
        offer(KIND_ALLOC, tiny ? $urandom_range(0, 3) : pick_size(),
              $urandom_range(0, MAX_SLOTS - 1));
      else if (r < 97)
        offer(KIND_VACUUM, $urandom_range(0, PAGE_BYTES), $urandom_range(0, MAX_SLOTS - 1));
      else
        offer(KIND_INIT, $urandom_range(0, PAGE_BYTES), $urandom_range(0, MAX_SLOTS - 1));
    end
    if ($urandom_range(0, 3) == 0) drain();
  endtask

  task automatic run_random();
    int stop_at;
    int start;
    bit crowded_done;
    start        = items_sent;
    stop_at      = items_sent + RANDOM_ITEMS;
    crowded_done = 1'b0;
    while (items_sent < stop_at) begin
      if (!crowded_done && items_sent > start + 300) begin
        page_session(120, 40, 1'b1);
        crowded_done = 1'b1;
      end else if ($urandom_range(0, 99) < 85) begin
        page_session($urandom_range(1, 20), $urandom_range(5, 30), 1'b0);
      end else begin
        // Unstructured requests on whatever page is there.
        repeat ($urandom_range(1, 5))
          offer(kind_t'($urandom_range(0, 3)), $urandom_range(0, PAGE_BYTES),
                $urandom_range(0, MAX_SLOTS - 1));
      end
    end
  endtask

  // Reset, stimulus, drain and verdict.
  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    run_random();
    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("slotted_page_space_manager_unit: match");
    end else begin
      $display("slotted_page_space_manager_unit: mismatch");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/spsm_pkg.sv
sv/spsm_ram.sv
sv/slotted_page_space_manager_unit.sv
sv/spsm_checker.sv
sim/page_directory_checker.sv
sim/tb.sv
